[src/gdfs_pkg.sv]
// shared constants and control types for the graph traversal block
package gdfs_pkg;

  localparam int unsigned MAX_VERTICES_DEF = 64;
  localparam int unsigned MAX_DEGREE_DEF   = 64;
  localparam int unsigned VERT_W           = 6;
  localparam int unsigned CNT_W            = 7;
  localparam int unsigned COUNT_RESET      = 64;

  localparam logic CMD_ADD_EDGE = 1'b0;
  localparam logic CMD_TRAVERSE = 1'b1;

  // strobes toward the neighbor list and degree memories
  typedef struct packed {
    logic deg_rd;
    logic deg_wr;
    logic nbr_rd;
    logic nbr_wr;
  } graph_ctl_t;

  // strobes toward the visited and stack memories
  typedef struct packed {
    logic vis_rd;
    logic vis_wr;
    logic vis_set;
    logic stk_rd;
    logic stk_wr;
  } walk_ctl_t;

endpackage

[src/gdfs_in_if.sv]
// input channel: command beat with two vertex fields
interface gdfs_in_if import gdfs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              cmd;
  logic [VERT_W-1:0] vertex_a;
  logic [VERT_W-1:0] vertex_b;

  modport source (output valid, cmd, vertex_a, vertex_b, input ready);
  modport sink   (input valid, cmd, vertex_a, vertex_b, output ready);
endinterface

[src/gdfs_out_if.sv]
// output channel: one visited vertex or acknowledge per beat
interface gdfs_out_if import gdfs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [VERT_W-1:0] vertex;
  logic              last;
  logic              error;

  modport source (output valid, vertex, last, error, input ready);
  modport sink   (input valid, vertex, last, error, output ready);
endinterface

[src/graph_depth_first_traversal_top.sv]
// top level: adjacency-list graph store with depth-first walk sequencer
//
//  channel   dir  handshake         payload
//  in_i      in   valid/ready       cmd, vertex_a, vertex_b
//  out_o     out  valid/ready       vertex, last, error
//  cfg       in   cfg_we_i          cfg_wdata_i (vertex_count)
//
// add edge: two degree reads and two list writes, then the result register
// traverse: clears all MAX_VERTICES visited marks and sets up the source,
//   then fetches and scans each stored neighbor entry (testing its visited
//   mark and pushing a new vertex), pops each finished frame and finishes;
//   the degree, neighbor and visited memories are single-port
// bad vertex: one error beat
// reset clears control, degree valid bits and sets vertex_count to 64
// a full result register stalls the sequencer; the next command is taken
//   once the sequencer is back in idle, even with a result still waiting
module graph_depth_first_traversal_top import gdfs_pkg::*; #(
  parameter int unsigned MAX_VERTICES = MAX_VERTICES_DEF,
  parameter int unsigned MAX_DEGREE   = MAX_DEGREE_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  gdfs_in_if.sink          in_i,
  gdfs_out_if.source       out_o,
  input  logic             cfg_we_i,
  input  logic [CNT_W-1:0] cfg_wdata_i
);

  localparam int unsigned VIDX_W = $clog2(MAX_VERTICES);
  localparam int unsigned SLOT_W = $clog2(MAX_DEGREE);
  localparam int unsigned DEG_W  = $clog2(MAX_DEGREE + 1);
  localparam int unsigned NBR_AW = VIDX_W + SLOT_W;
  localparam int unsigned DEP_W  = $clog2(MAX_VERTICES + 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_ADD_RDA,
    S_ADD_CHK,
    S_ADD_WRB,
    S_RESP,
    S_CLEAR,
    S_START,
    S_FETCH,
    S_SCAN,
    S_TEST,
    S_POP,
    S_FINISH
  } state_e;

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [VERT_W-1:0] a_q, a_d;
  logic [VERT_W-1:0] b_q, b_d;
  logic [DEG_W-1:0]  deg_a_q, deg_a_d;
  logic [DEG_W-1:0]  deg_b_q, deg_b_d;
  logic              err_q, err_d;
  logic [VIDX_W-1:0] top_node_q, top_node_d;
  logic [DEG_W-1:0]  top_next_q, top_next_d;
  logic [DEP_W-1:0]  depth_q, depth_d;
  logic [DEP_W-1:0]  clr_q, clr_d;
  logic [VIDX_W-1:0] pend_q, pend_d;
  logic [VIDX_W-1:0] cand_q, cand_d;
  logic              out_valid_q, out_valid_d;
  logic [VERT_W-1:0] out_vertex_q, out_vertex_d;
  logic              out_last_q, out_last_d;
  logic              out_error_q, out_error_d;

  // memory side
  graph_ctl_t        gctl;
  logic [VIDX_W-1:0] deg_addr;
  logic [DEG_W-1:0]  deg_wdata;
  logic [DEG_W-1:0]  deg_rdata;
  logic [NBR_AW-1:0] nbr_addr;
  logic [VERT_W-1:0] nbr_wdata;
  logic [VERT_W-1:0] nbr_rdata;
  walk_ctl_t         wctl;
  logic [VIDX_W-1:0] vis_addr;
  logic              vis_rdata;
  logic [VIDX_W-1:0] stk_addr;
  logic [VIDX_W-1:0] stk_rnode;
  logic [DEG_W-1:0]  stk_rnext;

  // helpers
  logic [CNT_W-1:0]  n_active;
  logic              accept;
  logic              out_free;
  logic              a_bad_in, b_bad_in;
  logic              w_bad;
  logic              add_full;
  logic [DEG_W:0]    deg_a_plus2;
  logic [DEP_W-1:0]  depth_m1, depth_m2;

  // vertex_count saturates at the build size
  assign n_active = (count_q > CNT_W'(MAX_VERTICES)) ? CNT_W'(MAX_VERTICES) : count_q;

  assign in_i.ready = (state_q == S_IDLE);
  assign accept     = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;

  assign a_bad_in = ({1'b0, in_i.vertex_a} >= n_active);
  assign b_bad_in = ({1'b0, in_i.vertex_b} >= n_active);
  // neighbors at or above a lowered count are stale and skipped
  assign w_bad    = ({1'b0, nbr_rdata} >= n_active);

  // list room check: a self loop needs two free slots
  assign deg_a_plus2 = {1'b0, deg_a_q} + (DEG_W + 1)'(2);
  always_comb begin
    if (a_q == b_q) begin
      add_full = deg_a_plus2 > (DEG_W + 1)'(MAX_DEGREE);
    end else begin
      add_full = (deg_a_q >= DEG_W'(MAX_DEGREE)) || (deg_rdata >= DEG_W'(MAX_DEGREE));
    end
  end

  assign depth_m1 = depth_q - DEP_W'(1);
  assign depth_m2 = depth_q - DEP_W'(2);

  // sequencer
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    a_d          = a_q;
    b_d          = b_q;
    deg_a_d      = deg_a_q;
    deg_b_d      = deg_b_q;
    err_d        = err_q;
    top_node_d   = top_node_q;
    top_next_d   = top_next_q;
    depth_d      = depth_q;
    clr_d        = clr_q;
    pend_d       = pend_q;
    cand_d       = cand_q;
    out_valid_d  = out_valid_q && !out_o.ready;
    out_vertex_d = out_vertex_q;
    out_last_d   = out_last_q;
    out_error_d  = out_error_q;

    gctl      = '0;
    deg_addr  = top_node_q;
    deg_wdata = '0;
    nbr_addr  = {top_node_q, top_next_q[SLOT_W-1:0]};
    nbr_wdata = '0;
    wctl      = '0;
    vis_addr  = cand_q;
    stk_addr  = depth_m1[VIDX_W-1:0];

    if (cfg_we_i) begin
      count_d = cfg_wdata_i;
    end

    unique case (state_q)
      S_IDLE: begin
        deg_addr = in_i.vertex_a[VIDX_W-1:0];
        if (accept) begin
          a_d = in_i.vertex_a;
          b_d = in_i.vertex_b;
          if (in_i.cmd == CMD_ADD_EDGE) begin
            if (a_bad_in || b_bad_in) begin
              err_d   = 1'b1;
              state_d = S_RESP;
            end else begin
              gctl.deg_rd = 1'b1;
              state_d     = S_ADD_RDA;
            end
          end else begin
            if (a_bad_in) begin
              err_d   = 1'b1;
              state_d = S_RESP;
            end else begin
              clr_d   = '0;
              state_d = S_CLEAR;
            end
          end
        end
      end

      S_ADD_RDA: begin
        deg_a_d     = deg_rdata;
        deg_addr    = b_q[VIDX_W-1:0];
        gctl.deg_rd = 1'b1;
        state_d     = S_ADD_CHK;
      end

      S_ADD_CHK: begin
        if (add_full) begin
          err_d   = 1'b1;
          state_d = S_RESP;
        end else begin
          // append b to the list of a
          deg_addr    = a_q[VIDX_W-1:0];
          deg_wdata   = deg_a_q + DEG_W'(1);
          gctl.deg_wr = 1'b1;
          nbr_addr    = {a_q[VIDX_W-1:0], deg_a_q[SLOT_W-1:0]};
          nbr_wdata   = b_q;
          gctl.nbr_wr = 1'b1;
          deg_b_d     = (a_q == b_q) ? (deg_a_q + DEG_W'(1)) : deg_rdata;
          state_d     = S_ADD_WRB;
        end
      end

      S_ADD_WRB: begin
        deg_addr    = b_q[VIDX_W-1:0];
        deg_wdata   = deg_b_q + DEG_W'(1);
        gctl.deg_wr = 1'b1;
        nbr_addr    = {b_q[VIDX_W-1:0], deg_b_q[SLOT_W-1:0]};
        nbr_wdata   = a_q;
        gctl.nbr_wr = 1'b1;
        err_d       = 1'b0;
        state_d     = S_RESP;
      end

      S_RESP: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_vertex_d = '0;
          out_last_d   = 1'b1;
          out_error_d  = err_q;
          err_d        = 1'b0;
          state_d      = S_IDLE;
        end
      end

      S_CLEAR: begin
        vis_addr     = clr_q[VIDX_W-1:0];
        wctl.vis_wr  = 1'b1;
        wctl.vis_set = 1'b0;
        clr_d        = clr_q + DEP_W'(1);
        if (clr_q == DEP_W'(MAX_VERTICES - 1)) begin
          state_d = S_START;
        end
      end

      S_START: begin
        vis_addr     = a_q[VIDX_W-1:0];
        wctl.vis_wr  = 1'b1;
        wctl.vis_set = 1'b1;
        pend_d       = a_q[VIDX_W-1:0];
        top_node_d   = a_q[VIDX_W-1:0];
        top_next_d   = '0;
        depth_d      = DEP_W'(1);
        state_d      = S_FETCH;
      end

      S_FETCH: begin
        gctl.deg_rd = 1'b1;
        gctl.nbr_rd = 1'b1;
        state_d     = S_SCAN;
      end

      S_SCAN: begin
        if (top_next_q >= deg_rdata) begin
          // frame exhausted
          if (depth_q == DEP_W'(1)) begin
            state_d = S_FINISH;
          end else begin
            stk_addr    = depth_m2[VIDX_W-1:0];
            wctl.stk_rd = 1'b1;
            depth_d     = depth_m1;
            state_d     = S_POP;
          end
        end else begin
          top_next_d = top_next_q + DEG_W'(1);
          if (w_bad) begin
            state_d = S_FETCH;
          end else begin
            cand_d      = nbr_rdata[VIDX_W-1:0];
            vis_addr    = nbr_rdata[VIDX_W-1:0];
            wctl.vis_rd = 1'b1;
            state_d     = S_TEST;
          end
        end
      end

      S_TEST: begin
        if (vis_rdata) begin
          // already seen: fetch the next entry of the same frame
          gctl.deg_rd = 1'b1;
          gctl.nbr_rd = 1'b1;
          state_d     = S_SCAN;
        end else if (out_free) begin
          // first visit: release the held vertex, push the current frame
          vis_addr     = cand_q;
          wctl.vis_wr  = 1'b1;
          wctl.vis_set = 1'b1;
          out_valid_d  = 1'b1;
          out_vertex_d = VERT_W'(pend_q);
          out_last_d   = 1'b0;
          out_error_d  = 1'b0;
          pend_d       = cand_q;
          stk_addr     = depth_m1[VIDX_W-1:0];
          wctl.stk_wr  = 1'b1;
          top_node_d   = cand_q;
          top_next_d   = '0;
          depth_d      = depth_q + DEP_W'(1);
          state_d      = S_FETCH;
        end
      end

      S_POP: begin
        top_node_d = stk_rnode;
        top_next_d = stk_rnext;
        state_d    = S_FETCH;
      end

      S_FINISH: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_vertex_d = VERT_W'(pend_q);
          out_last_d   = 1'b1;
          out_error_d  = 1'b0;
          depth_d      = '0;
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      count_q      <= CNT_W'(COUNT_RESET);
      a_q          <= '0;
      b_q          <= '0;
      deg_a_q      <= '0;
      deg_b_q      <= '0;
      err_q        <= 1'b0;
      top_node_q   <= '0;
      top_next_q   <= '0;
      depth_q      <= '0;
      clr_q        <= '0;
      pend_q       <= '0;
      cand_q       <= '0;
      out_valid_q  <= 1'b0;
      out_vertex_q <= '0;
      out_last_q   <= 1'b0;
      out_error_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      count_q      <= count_d;
      a_q          <= a_d;
      b_q          <= b_d;
      deg_a_q      <= deg_a_d;
      deg_b_q      <= deg_b_d;
      err_q        <= err_d;
      top_node_q   <= top_node_d;
      top_next_q   <= top_next_d;
      depth_q      <= depth_d;
      clr_q        <= clr_d;
      pend_q       <= pend_d;
      cand_q       <= cand_d;
      out_valid_q  <= out_valid_d;
      out_vertex_q <= out_vertex_d;
      out_last_q   <= out_last_d;
      out_error_q  <= out_error_d;
    end
  end

  assign out_o.valid  = out_valid_q;
  assign out_o.vertex = out_vertex_q;
  assign out_o.last   = out_last_q;
  assign out_o.error  = out_error_q;

  gdfs_graph_mem #(
    .MAX_VERTICES (MAX_VERTICES),
    .MAX_DEGREE   (MAX_DEGREE)
  ) u_graph_mem (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (gctl),
    .deg_addr_i  (deg_addr),
    .deg_wdata_i (deg_wdata),
    .deg_rdata_o (deg_rdata),
    .nbr_addr_i  (nbr_addr),
    .nbr_wdata_i (nbr_wdata),
    .nbr_rdata_o (nbr_rdata)
  );

  gdfs_walk_mem #(
    .MAX_VERTICES (MAX_VERTICES),
    .MAX_DEGREE   (MAX_DEGREE)
  ) u_walk_mem (
    .clk_i       (clk_i),
    .ctl_i       (wctl),
    .vis_addr_i  (vis_addr),
    .vis_rdata_o (vis_rdata),
    .stk_addr_i  (stk_addr),
    .stk_wnode_i (top_node_q),
    .stk_wnext_i (top_next_q),
    .stk_rnode_o (stk_rnode),
    .stk_rnext_o (stk_rnext)
  );

  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= DEP_W'(MAX_VERTICES))
    else $error("walk stack deeper than the vertex count");

  a_scan_has_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN || state_q == S_TEST) |-> (depth_q != '0))
    else $error("neighbor scan with an empty stack");

  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wctl.stk_wr |=> (depth_q == $past(depth_q) + DEP_W'(1)))
    else $error("stack push did not raise the depth");

endmodule

[src/gdfs_graph_mem.sv]
// neighbor list memory and per-vertex degree memory with reset valid bits
module gdfs_graph_mem import gdfs_pkg::*; #(
  parameter int unsigned MAX_VERTICES = MAX_VERTICES_DEF,
  parameter int unsigned MAX_DEGREE   = MAX_DEGREE_DEF,
  localparam int unsigned VIDX_W    = $clog2(MAX_VERTICES),
  localparam int unsigned SLOT_W    = $clog2(MAX_DEGREE),
  localparam int unsigned DEG_W     = $clog2(MAX_DEGREE + 1),
  localparam int unsigned NBR_AW    = VIDX_W + SLOT_W,
  localparam int unsigned NBR_DEPTH = 2 ** NBR_AW
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  graph_ctl_t        ctl_i,
  input  logic [VIDX_W-1:0] deg_addr_i,
  input  logic [DEG_W-1:0]  deg_wdata_i,
  output logic [DEG_W-1:0]  deg_rdata_o,
  input  logic [NBR_AW-1:0] nbr_addr_i,
  input  logic [VERT_W-1:0] nbr_wdata_i,
  output logic [VERT_W-1:0] nbr_rdata_o
);

  logic [DEG_W-1:0]        deg_mem [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] deg_vld_q;
  logic [DEG_W-1:0]        deg_raw_q;
  logic                    deg_hit_q;
  logic [VERT_W-1:0]       nbr_mem [NBR_DEPTH];
  logic [VERT_W-1:0]       nbr_q;

  // valid bits stand in for the all-zero reset of the degree table
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deg_vld_q <= '0;
    end else if (ctl_i.deg_wr) begin
      deg_vld_q[deg_addr_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.deg_wr) begin
      deg_mem[deg_addr_i] <= deg_wdata_i;
    end
    if (ctl_i.deg_rd) begin
      deg_raw_q <= deg_mem[deg_addr_i];
      deg_hit_q <= deg_vld_q[deg_addr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.nbr_wr) begin
      nbr_mem[nbr_addr_i] <= nbr_wdata_i;
    end
    if (ctl_i.nbr_rd) begin
      nbr_q <= nbr_mem[nbr_addr_i];
    end
  end

  assign deg_rdata_o = deg_hit_q ? deg_raw_q : '0;
  assign nbr_rdata_o = nbr_q;

  a_deg_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctl_i.deg_rd && ctl_i.deg_wr))
    else $error("degree read and write in the same cycle");

  a_deg_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.deg_wr |-> (deg_wdata_i <= DEG_W'(MAX_DEGREE)))
    else $error("degree written above list capacity");

  a_deg_valid_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.deg_wr |=> deg_vld_q[$past(deg_addr_i)])
    else $error("degree write did not set its valid bit");

endmodule

[src/gdfs_walk_mem.sv]
// visited marks and the frames of the walk stack below its top
module gdfs_walk_mem import gdfs_pkg::*; #(
  parameter int unsigned MAX_VERTICES = MAX_VERTICES_DEF,
  parameter int unsigned MAX_DEGREE   = MAX_DEGREE_DEF,
  localparam int unsigned VIDX_W = $clog2(MAX_VERTICES),
  localparam int unsigned DEG_W  = $clog2(MAX_DEGREE + 1)
) (
  input  logic              clk_i,
  input  walk_ctl_t         ctl_i,
  input  logic [VIDX_W-1:0] vis_addr_i,
  output logic              vis_rdata_o,
  input  logic [VIDX_W-1:0] stk_addr_i,
  input  logic [VIDX_W-1:0] stk_wnode_i,
  input  logic [DEG_W-1:0]  stk_wnext_i,
  output logic [VIDX_W-1:0] stk_rnode_o,
  output logic [DEG_W-1:0]  stk_rnext_o
);

  logic                      vis_mem [MAX_VERTICES];
  logic                      vis_q;
  logic [VIDX_W+DEG_W-1:0]   stk_mem [MAX_VERTICES];
  logic [VIDX_W+DEG_W-1:0]   stk_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.vis_wr) begin
      vis_mem[vis_addr_i] <= ctl_i.vis_set;
    end
    if (ctl_i.vis_rd) begin
      vis_q <= vis_mem[vis_addr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.stk_wr) begin
      stk_mem[stk_addr_i] <= {stk_wnode_i, stk_wnext_i};
    end
    if (ctl_i.stk_rd) begin
      stk_q <= stk_mem[stk_addr_i];
    end
  end

  assign vis_rdata_o = vis_q;
  assign stk_rnode_o = stk_q[VIDX_W+DEG_W-1:DEG_W];
  assign stk_rnext_o = stk_q[DEG_W-1:0];

endmodule
